@@ rtl/bdic_pkg.sv @@
// ----------------------------------------------------------------------------
// bdic_pkg
// Types and helper functions for the bounds-domain intersection check:
// interval cuts, known-bits member search and the per-span test.
// ----------------------------------------------------------------------------
package bdic_pkg;

    localparam int WIDE_SPANS  = 2;   // signed x unsigned cut
    localparam int PIECES      = 6;   // 32-bit aligned pieces
    localparam int PARTS       = 12;  // low-half parts after signed 32 cut
    localparam int STAGES      = 6;
    localparam logic [31:0] LO32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } span_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } span32_t;

    typedef struct packed {
        span_t      s1;
        span_t      s0;
        logic [1:0] ok;
    } cut_t;

    typedef struct packed {
        logic        found;
        logic [63:0] val;
    } member_t;

    // First half of the known-bits test on [lo, hi]
    typedef struct packed {
        logic        pre;    // value window overlaps span
        logic        need;   // lo itself is not a member
        logic        found;
        logic [63:0] nx;     // next member above lo
    } check_t;

    // Intersect [ulo, uhi] with a signed range seen in unsigned order.
    function automatic cut_t cut_by_signed(input logic [63:0] ulo, input logic [63:0] uhi,
                                           input logic [63:0] slo, input logic [63:0] shi);
        cut_t        r;
        logic [63:0] lo_max;
        logic [63:0] hi_min;
        lo_max = (ulo > slo) ? ulo : slo;
        hi_min = (uhi < shi) ? uhi : shi;
        r.s1.lo = lo_max;
        r.s1.hi = uhi;
        if (slo <= shi)
        begin
            r.s0.lo = lo_max;
            r.s0.hi = hi_min;
            r.ok    = {1'b0, lo_max <= hi_min};
        end
        else
        begin
            // wrapping range: [0, shi] and [slo, max]
            r.s0.lo = ulo;
            r.s0.hi = hi_min;
            r.ok    = {lo_max <= uhi, ulo <= hi_min};
        end
        return r;
    endfunction

    // Smallest x > z with (x & ~m) == v.
    function automatic member_t next_member(input logic [63:0] v, input logic [63:0] m,
                                            input logic [63:0] z);
        member_t     r;
        logic [63:0] j;
        logic [63:0] diff;
        logic [63:0] sr;
        logic [63:0] okp;
        logic [63:0] c;
        logic [63:0] lsb;
        j    = z + 64'd1;
        diff = (j ^ v) & ~m;
        // smear right: sr[p] set when diff has a bit at p or above
        sr = diff;
        sr = sr | (sr >> 1);
        sr = sr | (sr >> 2);
        sr = sr | (sr >> 4);
        sr = sr | (sr >> 8);
        sr = sr | (sr >> 16);
        sr = sr | (sr >> 32);
        okp = ~(sr >> 1);             // no differing bit above p
        c   = ~j & (v | m) & okp;
        lsb = c & (~c + 64'd1);
        r.found = (z != '1) && ((diff == '0) || (c != '0));
        if (diff == '0)
            r.val = j;
        else
            r.val = (j & ~(lsb | (lsb - 64'd1))) | lsb | (v & (lsb - 64'd1));
        return r;
    endfunction

    function automatic check_t check_prep(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [63:0] v, input logic [63:0] m);
        check_t  c;
        member_t nm;
        nm      = next_member(v, m, lo);
        c.pre   = !((v > hi) || ((v | m) < lo));
        c.need  = v != (lo & ~m);
        c.found = nm.found;
        c.nx    = nm.val;
        return c;
    endfunction

    function automatic logic check_done(input check_t c, input logic [63:0] hi);
        return c.pre && (!c.need || (c.found && (c.nx <= hi)));
    endfunction

endpackage

@@ rtl/bounds_domain_intersection_check.sv @@
// ----------------------------------------------------------------------------
// bounds_domain_intersection_check
// Decides whether one 64-bit value lies in all five abstract domains of a
// register: known bits, signed/unsigned 64-bit and signed/unsigned 32-bit.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one query per transfer: the
//   known-bits pair and the four ranges. Output channel (out_valid /
//   out_stall) returns one transfer per query with the single flag
//   intersects. Results leave in query order.
// Stages and throughput
//   Six register stages: input, 64-bit pieces, piece member search, low-half
//   parts, part member search, result. One query per cycle is taken and
//   delivered while the receiver takes results; each stage is set by one
//   64-bit add and compare of the member search.
// Stall
//   When out_stall holds a result, earlier stages keep moving until they run
//   into it; in_stall rises only when every stage is occupied. Empty stages
//   are squeezed out.
// Reset
//   rst_n clears all stage valid bits; no state is kept between queries.
// ----------------------------------------------------------------------------
module bounds_domain_intersection_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        known_value,
    input  logic [63:0]        known_mask,
    input  logic signed [63:0] signed_low,
    input  logic signed [63:0] signed_high,
    input  logic [63:0]        unsigned_low,
    input  logic [63:0]        unsigned_high,
    input  logic signed [31:0] signed_low_32,
    input  logic signed [31:0] signed_high_32,
    input  logic [31:0]        unsigned_low_32,
    input  logic [31:0]        unsigned_high_32,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               intersects
);

    // ---------------- stage flow control ----------------
    logic [bdic_pkg::STAGES-1:0] vld_reg;
    logic [bdic_pkg::STAGES-1:0] vld_next;
    logic [bdic_pkg::STAGES-1:0] adv;     // stage can take a new item

    always_comb
    begin
        adv[bdic_pkg::STAGES-1] = !vld_reg[bdic_pkg::STAGES-1] || !out_stall;
        for (int k = bdic_pkg::STAGES - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < bdic_pkg::STAGES; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[bdic_pkg::STAGES-1];

    // ---------------- stage 0: input register ----------------
    logic [63:0] s0_val_reg, s0_mask_reg;
    logic [63:0] s0_slo_reg, s0_shi_reg, s0_ulo_reg, s0_uhi_reg;
    logic [31:0] s0_slo32_reg, s0_shi32_reg, s0_ulo32_reg, s0_uhi32_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_val_reg   <= known_value;
            s0_mask_reg  <= known_mask;
            s0_slo_reg   <= $unsigned(signed_low);
            s0_shi_reg   <= $unsigned(signed_high);
            s0_ulo_reg   <= unsigned_low;
            s0_uhi_reg   <= unsigned_high;
            s0_slo32_reg <= $unsigned(signed_low_32);
            s0_shi32_reg <= $unsigned(signed_high_32);
            s0_ulo32_reg <= unsigned_low_32;
            s0_uhi32_reg <= unsigned_high_32;
        end
    end

    // Cut the two 64-bit ranges, then split each span on 32-bit boundaries:
    // head piece, optional middle run of whole blocks, tail piece.
    bdic_pkg::cut_t  s0_cut;
    bdic_pkg::span_t s1_piece_next [bdic_pkg::PIECES];
    logic [bdic_pkg::PIECES-1:0] s1_pok_next;

    always_comb
    begin
        logic [63:0] x;
        logic [63:0] y;
        logic [31:0] xh;
        logic [31:0] yh;
        logic        ok;
        s0_cut = bdic_pkg::cut_by_signed(s0_ulo_reg, s0_uhi_reg, s0_slo_reg, s0_shi_reg);
        for (int w = 0; w < bdic_pkg::WIDE_SPANS; w++)
        begin
            x  = (w == 0) ? s0_cut.s0.lo : s0_cut.s1.lo;
            y  = (w == 0) ? s0_cut.s0.hi : s0_cut.s1.hi;
            ok = s0_cut.ok[w];
            xh = x[63:32];
            yh = y[63:32];
            if (xh == yh)
            begin
                s1_piece_next[3*w]   = '{lo: x, hi: y};
                s1_pok_next[3*w]     = ok;
                s1_piece_next[3*w+1] = '{lo: x, hi: y};
                s1_pok_next[3*w+1]   = 1'b0;
                s1_piece_next[3*w+2] = '{lo: x, hi: y};
                s1_pok_next[3*w+2]   = 1'b0;
            end
            else
            begin
                s1_piece_next[3*w]   = '{lo: x, hi: {xh, bdic_pkg::LO32}};
                s1_pok_next[3*w]     = ok;
                s1_piece_next[3*w+1] = '{lo: {xh + 32'd1, 32'd0},
                                         hi: {yh - 32'd1, bdic_pkg::LO32}};
                s1_pok_next[3*w+1]   = ok && (xh < (yh - 32'd1));
                s1_piece_next[3*w+2] = '{lo: {yh, 32'd0}, hi: y};
                s1_pok_next[3*w+2]   = ok;
            end
        end
    end

    // ---------------- stage 1: 64-bit pieces ----------------
    bdic_pkg::span_t s1_piece_reg [bdic_pkg::PIECES];
    logic [bdic_pkg::PIECES-1:0] s1_pok_reg;
    logic [63:0] s1_v_reg, s1_m_reg;
    logic [31:0] s1_slo32_reg, s1_shi32_reg, s1_ulo32_reg, s1_uhi32_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_piece_reg <= s1_piece_next;
            s1_pok_reg   <= s1_pok_next;
            s1_v_reg     <= s0_val_reg & ~s0_mask_reg;   // drop value bits under mask
            s1_m_reg     <= s0_mask_reg;
            s1_slo32_reg <= s0_slo32_reg;
            s1_shi32_reg <= s0_shi32_reg;
            s1_ulo32_reg <= s0_ulo32_reg;
            s1_uhi32_reg <= s0_uhi32_reg;
        end
    end

    // ---------------- stage 2: member search per piece ----------------
    bdic_pkg::check_t s2_chk_reg [bdic_pkg::PIECES];
    logic [63:0] s2_hi_reg [bdic_pkg::PIECES];
    logic [31:0] s2_lo32_reg [bdic_pkg::PIECES];
    logic [bdic_pkg::PIECES-1:0] s2_pok_reg;
    logic [31:0] s2_v32_reg, s2_m32_reg;
    logic [31:0] s2_slo32_reg, s2_shi32_reg, s2_ulo32_reg, s2_uhi32_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < bdic_pkg::PIECES; i++)
            begin
                s2_chk_reg[i]  <= bdic_pkg::check_prep(s1_piece_reg[i].lo, s1_piece_reg[i].hi,
                                                       s1_v_reg, s1_m_reg);
                s2_hi_reg[i]   <= s1_piece_reg[i].hi;
                s2_lo32_reg[i] <= s1_piece_reg[i].lo[31:0];
            end
            s2_pok_reg   <= s1_pok_reg;
            s2_v32_reg   <= s1_v_reg[31:0];
            s2_m32_reg   <= s1_m_reg[31:0];
            s2_slo32_reg <= s1_slo32_reg;
            s2_shi32_reg <= s1_shi32_reg;
            s2_ulo32_reg <= s1_ulo32_reg;
            s2_uhi32_reg <= s1_uhi32_reg;
        end
    end

    // Surviving pieces drop to their low half, get clamped by the unsigned
    // 32-bit range and cut by the signed 32-bit range.
    bdic_pkg::span32_t s3_part_next [bdic_pkg::PARTS];
    logic [bdic_pkg::PARTS-1:0] s3_qok_next;

    always_comb
    begin
        logic [31:0]     l;
        logic [31:0]     r;
        logic            pass;
        bdic_pkg::cut_t  pc;
        for (int i = 0; i < bdic_pkg::PIECES; i++)
        begin
            pass = s2_pok_reg[i] && bdic_pkg::check_done(s2_chk_reg[i], s2_hi_reg[i]);
            l    = (s2_lo32_reg[i] > s2_ulo32_reg) ? s2_lo32_reg[i] : s2_ulo32_reg;
            r    = (s2_hi_reg[i][31:0] < s2_uhi32_reg) ? s2_hi_reg[i][31:0] : s2_uhi32_reg;
            pc   = bdic_pkg::cut_by_signed({32'd0, l}, {32'd0, r},
                                           {32'd0, s2_slo32_reg}, {32'd0, s2_shi32_reg});
            s3_part_next[2*i]   = '{lo: pc.s0.lo[31:0], hi: pc.s0.hi[31:0]};
            s3_part_next[2*i+1] = '{lo: pc.s1.lo[31:0], hi: pc.s1.hi[31:0]};
            s3_qok_next[2*i]    = pass && (l <= r) && pc.ok[0];
            s3_qok_next[2*i+1]  = pass && (l <= r) && pc.ok[1];
        end
    end

    // ---------------- stage 3: low-half parts ----------------
    bdic_pkg::span32_t s3_part_reg [bdic_pkg::PARTS];
    logic [bdic_pkg::PARTS-1:0] s3_qok_reg;
    logic [31:0] s3_v32_reg, s3_m32_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_part_reg <= s3_part_next;
            s3_qok_reg  <= s3_qok_next;
            s3_v32_reg  <= s2_v32_reg;
            s3_m32_reg  <= s2_m32_reg;
        end
    end

    // ---------------- stage 4: member search per part ----------------
    bdic_pkg::check_t s4_chk_reg [bdic_pkg::PARTS];
    logic [31:0] s4_hi_reg [bdic_pkg::PARTS];
    logic [bdic_pkg::PARTS-1:0] s4_qok_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int i = 0; i < bdic_pkg::PARTS; i++)
            begin
                s4_chk_reg[i] <= bdic_pkg::check_prep({32'd0, s3_part_reg[i].lo},
                                                      {32'd0, s3_part_reg[i].hi},
                                                      {32'd0, s3_v32_reg},
                                                      {32'd0, s3_m32_reg});
                s4_hi_reg[i]  <= s3_part_reg[i].hi;
            end
            s4_qok_reg <= s3_qok_reg;
        end
    end

    // ---------------- stage 5: result register ----------------
    logic hit;
    logic intersects_reg;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < bdic_pkg::PARTS; i++)
            hit = hit | (s4_qok_reg[i] &&
                         bdic_pkg::check_done(s4_chk_reg[i], {32'd0, s4_hi_reg[i]}));
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
            intersects_reg <= hit;
    end

    assign intersects = intersects_reg;

    // ---------------- assertions ----------------
    // input backs up only once every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("in_stall with an empty stage");

    // a free receiver never backs up the sender
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("in_stall while out_stall is low");

    // a new result only comes from the member-search stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(vld_reg[4]))
        else $error("out_valid rose without an item in stage 4");

    // a middle run of blocks always has a head and a tail piece
    a_mid_piece0: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && s1_pok_reg[1]) |-> (s1_pok_reg[0] && s1_pok_reg[2]))
        else $error("middle piece without outer pieces, first span");

    a_mid_piece1: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && s1_pok_reg[4]) |-> (s1_pok_reg[3] && s1_pok_reg[5]))
        else $error("middle piece without outer pieces, second span");

endmodule
